### hdl/pct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

	// default build values
	localparam int CHANNELS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 24;

	// fixed field widths of the ports
	localparam int REQ_W     = 2;
	localparam int CH_W      = 3;
	localparam int DUR_W     = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_W     = 8;

	// register reset values
	localparam logic [CFG_W-1:0] PERIOD_RESET    = CFG_W'(20000);
	localparam logic [CFG_W-1:0] TOLERANCE_RESET = CFG_W'(10);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(1);

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_SET  = 2'd0,
		REQ_HALT = 2'd1,
		REQ_TICK = 2'd2
	} req_e_t;

	// per-channel commands for one word
	typedef struct packed {
		logic set;
		logic halt;
		logic tick;
	} chan_ctl_t;

endpackage

`default_nettype wire

### hdl/pwm_channel_tolerance_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Multi-channel PWM generator with a shared period and a tolerance snap on phase
// lengths. Each input word is a set (high time for one channel), a halt, or one timer
// tick that counts down every running channel in parallel. One word is taken per clock
// while the result slot is free or being taken: high-time snapping is done as the word
// enters the input stage, and the channel state and result word are registered as
// it leaves that stage; words stream back to back unless out_ready stalls. The result
// shows every channel's pin level and running flag after the word's update. Period
// and tolerance writes take effect on a channel at its next set or halt; write them
// only while no word is in flight.
module pwm_channel_tolerance_generator #(
	parameter int CHANNELS   = pct_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = pct_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [pct_pkg::REQ_W-1:0]     req_type,
	input  wire logic [pct_pkg::CH_W-1:0]      channel,
	input  wire logic [pct_pkg::DUR_W-1:0]     high_time,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pct_pkg::CFG_W-1:0]     cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [pct_pkg::OUT_W-1:0]     pin_levels,
	output logic      [pct_pkg::OUT_W-1:0]     active_mask
);

	logic [pct_pkg::CFG_W-1:0]  period_q;
	logic [pct_pkg::CFG_W-1:0]  tolerance_q;
	logic [COUNT_BITS-1:0]      per;
	logic [COUNT_BITS-1:0]      tol;

	logic [COUNT_BITS-1:0]      clamp_hi;
	logic [COUNT_BITS-1:0]      clamp_lo;
	logic                       clamp_stop;

	logic                       valid_s1;
	logic [pct_pkg::REQ_W-1:0]  op_s1;
	logic [pct_pkg::CH_W-1:0]   ch_s1;
	logic [COUNT_BITS-1:0]      hi_s1;
	logic [COUNT_BITS-1:0]      lo_s1;
	logic                       stop_s1;

	logic                       out_valid_q;
	logic                       adv;
	logic                       do_set;
	logic                       do_halt;
	logic                       do_tick;

	logic [CHANNELS-1:0]        pin_v;
	logic [CHANNELS-1:0]        act_v;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= pct_pkg::PERIOD_RESET;
			tolerance_q <= pct_pkg::TOLERANCE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pct_pkg::CFG_PERIOD:    period_q    <= cfg_data;
				pct_pkg::CFG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign per = COUNT_BITS'(period_q);
	assign tol = COUNT_BITS'(tolerance_q);

	// snap high time on the way into the input stage
	pct_clamp #(
		.COUNT_BITS(COUNT_BITS)
	) u_clamp (
		.dur (high_time),
		.per (per),
		.tol (tol),
		.hi  (clamp_hi),
		.lo  (clamp_lo),
		.stop(clamp_stop)
	);

	// handshake: stage 1 moves on when the result slot is free or being taken
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= req_type;
			ch_s1   <= channel;
			hi_s1   <= clamp_hi;
			lo_s1   <= clamp_lo;
			stop_s1 <= clamp_stop;
		end
	end

	// decode the word into channel commands
	always_comb begin
		do_set  = 1'b0;
		do_halt = 1'b0;
		do_tick = 1'b0;
		unique case (op_s1)
			pct_pkg::REQ_SET: begin
				do_set  = adv && !stop_s1;
				do_halt = adv && stop_s1;
			end
			pct_pkg::REQ_HALT: do_halt = adv;
			pct_pkg::REQ_TICK: do_tick = adv;
			default: ;
		endcase
	end

	// channel bank
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		pct_pkg::chan_ctl_t ctl;
		logic               hit;

		assign hit      = (32'(ch_s1) == 32'(c));
		assign ctl.set  = do_set && hit;
		assign ctl.halt = do_halt && hit;
		assign ctl.tick = do_tick;

		pct_chan #(
			.COUNT_BITS(COUNT_BITS)
		) u_chan (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.hi    (hi_s1),
			.lo    (lo_s1),
			.per   (per),
			.pin   (pin_v[c]),
			.active(act_v[c])
		);
	end

	// result word: channel state only moves when a new result is produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	for (genvar i = 0; i < pct_pkg::OUT_W; i++) begin : g_out
		if (i < CHANNELS) begin : g_used
			assign pin_levels[i]  = pin_v[i];
			assign active_mask[i] = act_v[i];
		end else begin : g_pad
			assign pin_levels[i]  = 1'b0;
			assign active_mask[i] = 1'b0;
		end
	end

`ifndef ASSERT_OFF
	// a stopped channel always drives its pin low
	a_idle_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		(pin_levels & ~active_mask) == '0)
		else $error("idle channel with pin high");

	// channel state holds when no word is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(pin_levels) && $stable(active_mask)))
		else $error("channel state changed without a word");

	// every processed word offers a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed word without result");

	// result slot not overwritten while held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !adv)
		else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

### hdl/pct_clamp.sv
`timescale 1ns / 1ps
`default_nettype none

module pct_clamp #(
	parameter int COUNT_BITS = pct_pkg::COUNT_BITS_DEF
) (
	input  wire logic [pct_pkg::DUR_W-1:0] dur,
	input  wire logic [COUNT_BITS-1:0]     per,
	input  wire logic [COUNT_BITS-1:0]     tol,
	output logic      [COUNT_BITS-1:0]     hi,
	output logic      [COUNT_BITS-1:0]     lo,
	output logic                           stop
);

	logic [COUNT_BITS-1:0] req_hi;
	logic [COUNT_BITS-1:0] cut_hi;
	logic [COUNT_BITS-1:0] rest_lo;
	logic                  full_duty;

	// snap requested high time to tolerance and period
	always_comb begin
		req_hi    = COUNT_BITS'(dur);
		cut_hi    = (req_hi > per) ? per : req_hi;
		rest_lo   = per - cut_hi;
		full_duty = (rest_lo < tol);
		hi        = full_duty ? per : cut_hi;
		lo        = full_duty ? '0 : rest_lo;
		stop      = (req_hi < tol) || (hi == '0);
	end

endmodule

`default_nettype wire

### hdl/pct_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module pct_chan #(
	parameter int COUNT_BITS = pct_pkg::COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pct_pkg::chan_ctl_t    ctl,
	input  wire logic [COUNT_BITS-1:0] hi,
	input  wire logic [COUNT_BITS-1:0] lo,
	input  wire logic [COUNT_BITS-1:0] per,
	output logic                       pin,
	output logic                       active
);

	logic                  pin_q;
	logic                  next_high_q;
	logic [COUNT_BITS-1:0] high_q;
	logic [COUNT_BITS-1:0] low_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic                  running;
	logic                  expire;

	assign running = (high_q != '0);
	assign expire  = (rem_q[COUNT_BITS-1:1] == '0);

	// channel state: halt, set, or count down and toggle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q       <= 1'b0;
			next_high_q <= 1'b1;
			high_q      <= '0;
			low_q       <= '0;
			rem_q       <= '0;
		end else if (ctl.halt) begin
			if (running) begin
				high_q      <= '0;
				low_q       <= per;
				next_high_q <= 1'b1;
				pin_q       <= 1'b0;
				rem_q       <= '0;
			end
		end else if (ctl.set) begin
			// an idle channel fires a high phase on the next tick
			if (!running) begin
				next_high_q <= 1'b1;
				rem_q       <= COUNT_BITS'(1);
			end
			high_q <= hi;
			low_q  <= lo;
		end else if (ctl.tick && running) begin
			if (!expire) begin
				rem_q <= rem_q - COUNT_BITS'(1);
			end else if (next_high_q) begin
				pin_q       <= 1'b1;
				rem_q       <= high_q;
				next_high_q <= 1'b0;
			end else begin
				// zero low time keeps the pin high for full duty
				if (low_q == '0) begin
					rem_q <= high_q;
				end else begin
					pin_q <= 1'b0;
					rem_q <= low_q;
				end
				next_high_q <= 1'b1;
			end
		end
	end

	assign pin    = pin_q;
	assign active = running;

endmodule

`default_nettype wire
